// File: sv/tcw_pkg.sv
package tcw_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE  = 2'd1;
    localparam logic [ATTR_W-1:0]    RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0]    RESET_CELL = {RESET_ATTR, CH_SPACE};

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input beat taken, commit the item
        logic pass_en;   // step the store sweep
        logic load_out;  // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_pass; // the offered item needs a sweep (clear or scroll)
        logic pass_done; // sweep counter at its end
        logic out_free;  // output register can take a result this cycle
    } ctrl_stat_t;

endpackage

// File: sv/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/tcw_ctrl.sv
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::ctrl_stat_t stat,
    output tcw_pkg::ctrl_cmd_t  cmd
);

    import tcw_pkg::*;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_PASS,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    // Commands
    assign cmd.accept   = in_valid & ready_reg;
    assign cmd.pass_en  = (state_reg == ST_INIT) | (state_reg == ST_PASS);
    assign cmd.load_out = (state_reg == ST_DONE) & stat.out_free;
    assign in_ready     = ready_reg;

    // State and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ready_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    if (stat.pass_done)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= stat.need_pass ? ST_PASS : ST_DONE;
                    end
                end
                ST_PASS:
                begin
                    if (stat.pass_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_INIT;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: sv/tcw_datapath.sv
module tcw_datapath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcw_pkg::ctrl_cmd_t              cmd,
    output tcw_pkg::ctrl_stat_t             stat,
    input  logic                            cfg_valid,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data,
    input  logic [tcw_pkg::FUNC_W-1:0]      in_func,
    input  logic [tcw_pkg::CHAR_W-1:0]      in_char,
    input  logic [tcw_pkg::INDEX_W-1:0]     in_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::CELL_W-1:0]      out_cell_data,
    output logic [tcw_pkg::POS_W-1:0]       out_position,
    output logic                            out_shown,
    output logic                            out_scroll
);

    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COLX_W = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ROWX_W = $clog2(ROWS + 1);
    localparam int PH_W   = $clog2(TAB_STOP);

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [CNT_W-1:0]  CELLS_C   = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0]  COPY_END  = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0]  COLS_C    = CNT_W'(COLUMNS);
    localparam logic [COLX_W-1:0] COLS_X    = COLX_W'(COLUMNS);
    localparam logic [COLX_W-1:0] LAST_COL  = COLX_W'(COLUMNS - 1);
    localparam logic [COLX_W-1:0] TAB_X     = COLX_W'(TAB_STOP);
    localparam logic [ROWX_W-1:0] ROWS_X    = ROWX_W'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]   LAST_PH   = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0]   EDGE_PH   = PH_W'((COLUMNS - 1) % TAB_STOP);

    typedef enum logic [1:0] {
        PASS_INIT,
        PASS_CLEAR,
        PASS_SCROLL
    } pass_kind_t;

    // Cursor, tab phase (column modulo tab stop) and registers
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic              cen_reg;
    logic              scroll_reg;
    logic              rd_hit_reg;
    pass_kind_t        kind_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;

    logic [CELL_W-1:0] out_data_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_shown_reg;
    logic              out_scroll_reg;

    // Next cursor for a character
    logic [COLX_W-1:0] colx;
    logic [ROWX_W-1:0] rowx;
    logic [PH_W-1:0]   ph_next;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic              char_wr;
    logic              scroll_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [WIDE_W-1:0] pos_wide;
    logic [WIDE_W-1:0] idx_wide;
    logic              idx_hit;
    logic [CELL_W-1:0] blank;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_src;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    // Cursor address and position
    assign cur_addr = ADDR_W'(ADDR_W'(row_reg) * COLS_A) + ADDR_W'(col_reg);
    assign pos_wide = WIDE_W'(cur_addr);
    assign idx_wide = WIDE_W'(in_index);
    assign idx_hit  = idx_wide < WIDE_W'(CELLS_C);
    assign blank    = {attr_reg, CH_SPACE};

    // Character rules
    always_comb
    begin
        colx    = COLX_W'(col_reg);
        rowx    = ROWX_W'(row_reg);
        ph_next = phase_reg;
        char_wr = 1'b0;
        unique case (in_char)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    colx    = COLX_W'(col_reg) - 1'b1;
                    ph_next = (phase_reg == '0) ? LAST_PH : phase_reg - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    rowx    = ROWX_W'(row_reg) - 1'b1;
                    colx    = LAST_COL;
                    ph_next = EDGE_PH;
                end
            end
            CH_LF:
            begin
                rowx = ROWX_W'(row_reg) + 1'b1;
            end
            CH_CR:
            begin
                colx    = '0;
                ph_next = '0;
            end
            CH_TAB:
            begin
                colx    = COLX_W'(col_reg) + TAB_X - COLX_W'(phase_reg);
                ph_next = '0;
            end
            default:
            begin
                char_wr = 1'b1;
                colx    = COLX_W'(col_reg) + 1'b1;
                ph_next = (phase_reg == LAST_PH) ? '0 : phase_reg + 1'b1;
            end
        endcase
        // wrap at the end of a row
        if (colx >= COLS_X)
        begin
            colx    = '0;
            ph_next = '0;
            rowx    = rowx + 1'b1;
        end
    end

    assign scroll_next = rowx >= ROWS_X;
    assign col_next    = colx[COL_W-1:0];
    assign row_next    = scroll_next ? LAST_ROW : rowx[ROW_W-1:0];

    // Status
    assign stat.need_pass = (in_func == FUNC_CLEAR) | ((in_func == FUNC_WRITE) & scroll_next);
    assign stat.pass_done = cnt_reg == CELLS_C;
    assign stat.out_free  = ~out_valid_reg | out_ready;

    // Store port selection: sweep writes one behind its read
    assign cnt_m1  = cnt_reg - 1'b1;
    assign cnt_src = cnt_reg + COLS_C;

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_m1[ADDR_W-1:0];
        ram_wr_data = blank;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_src[ADDR_W-1:0];
        if (cmd.pass_en)
        begin
            // the final sweep cycle writes the last cell
            ram_wr_en = (cnt_reg != '0);
            if (kind_reg == PASS_INIT)
            begin
                ram_wr_data = RESET_CELL;
            end
            else if ((kind_reg == PASS_SCROLL) && (cnt_reg <= COPY_END))
            begin
                ram_wr_data = ram_rd_data;
            end
            ram_rd_en = (kind_reg == PASS_SCROLL) && (cnt_reg < COPY_END);
        end
        else if (cmd.accept)
        begin
            ram_wr_en   = (in_func == FUNC_WRITE) && char_wr;
            ram_wr_addr = cur_addr;
            ram_wr_data = {attr_reg, in_char};
            ram_rd_en   = in_func == FUNC_READ;
            ram_rd_addr = idx_wide[ADDR_W-1:0];
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Cursor, flags and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            phase_reg  <= '0;
            scroll_reg <= 1'b0;
            rd_hit_reg <= 1'b0;
            kind_reg   <= PASS_INIT;
            cnt_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            cnt_reg    <= '0;
            scroll_reg <= 1'b0;
            rd_hit_reg <= 1'b0;
            unique case (in_func)
                FUNC_WRITE:
                begin
                    col_reg    <= col_next;
                    row_reg    <= row_next;
                    phase_reg  <= ph_next;
                    scroll_reg <= scroll_next;
                    kind_reg   <= PASS_SCROLL;
                end
                FUNC_CLEAR:
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    phase_reg <= '0;
                    kind_reg  <= PASS_CLEAR;
                end
                FUNC_READ:
                begin
                    rd_hit_reg <= idx_hit;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.pass_en && !stat.pass_done)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
            cen_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEXT_ATTRIBUTE: attr_reg <= cfg_data;
                REG_CURSOR_ENABLE:  cen_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= rd_hit_reg ? ram_rd_data : '0;
            out_pos_reg    <= pos_wide[POS_W-1:0];
            out_shown_reg  <= cen_reg;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cell_data = out_data_reg;
    assign out_position  = out_pos_reg;
    assign out_shown     = out_shown_reg;
    assign out_scroll    = out_scroll_reg;

endmodule

// File: sv/text_console_writer.sv
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tuser: func; tdata: char_code, cell_index
// m_axis    out  tdata: cell_data, cursor_position, cursor_shown, did_scroll
// cfg       in   cfg_index selects text_attribute (0) or cursor_enable (1)
//
// A write, read or no-op item is accepted, then its result is loaded into
// the output register. Clear screen and a scrolling write add a sweep over
// the cell store (one cell per cycle, single port pair). After reset a sweep
// fills the store with blanks; s_axis_tready stays low meanwhile, cfg writes
// are always taken. A result waiting on m_axis_tready holds the block in its
// final cycle only.
module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,  // char_code, cell_index
    input  logic [1:0]                    s_axis_tuser,  // func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // cell_data, cursor_position,
                                                         // cursor_shown, did_scroll
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);

    import tcw_pkg::*;

    ctrl_cmd_t          cmd;
    ctrl_stat_t         stat;
    logic [CELL_W-1:0]  cell_data;
    logic [POS_W-1:0]   cursor_position;
    logic               cursor_shown;
    logic               did_scroll;

    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_func       (s_axis_tuser),
        .in_char       (s_axis_tdata[7:0]),
        .in_index      (s_axis_tdata[18:8]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_cell_data (cell_data),
        .out_position  (cursor_position),
        .out_shown     (cursor_shown),
        .out_scroll    (did_scroll)
    );

    // Result beat packing
    assign m_axis_tdata = {3'b000, did_scroll, cursor_shown, cursor_position, cell_data};

    // No sweep step while an item is being taken
    a_accept_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.pass_en)
        else $error("item accepted during a store sweep");

    // A result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an unconsumed one");

    // An item that needs no sweep goes straight to its result
    a_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !stat.need_pass) |=> !cmd.pass_en)
        else $error("sweep started for an item that needs none");

    // Input held off while a sweep is still running
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pass_en && !stat.pass_done) |=> !s_axis_tready)
        else $error("input ready during a store sweep");

endmodule
